/* hw/rtl/coprime_set_classifier_unit_macros.svh */
// Assertion macros shared by the coprime set classifier RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef COPRIME_SET_CLASSIFIER_UNIT_MACROS_SVH
`define COPRIME_SET_CLASSIFIER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define CSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* hw/rtl/csc_pkg.sv */
// Shared types and constants for the coprime set classifier.
// No dependencies; imported by every module of the block.
package csc_pkg;

    localparam int unsigned VALUE_BITS_DEF = 20;
    localparam longint unsigned SEEN_DEPTH_DEF = 64'd1048576;
    // width of the set tag kept per bitmap entry
    localparam int unsigned EPOCH_BITS = 8;

    typedef enum logic [1:0] {
        VERDICT_PAIRWISE    = 2'd0,
        VERDICT_SETWISE     = 2'd1,
        VERDICT_NOT_COPRIME = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        DIV_SEL_GCD = 2'd0,
        DIV_SEL_FAC = 2'd1,
        DIV_SEL_IDX = 2'd2
    } div_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     gcd_step;
        logic     gcd_store;
        logic     div_start;
        div_sel_t div_sel;
        logic     d_next;
        logic     n_from_q;
        logic     p_from_d;
        logic     p_from_n;
        logic     idx_load;
        logic     mem_rd;
        logic     mem_wr;
        logic     clr_step;
        logic     out_load;
        logic     set_clear;
    } csc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic y_zero;
        logic n_zero;
        logic n_one;
        logic dsq_gt_n;
        logic rem_zero;
        logic need_mod;
        logic clr_last;
        logic last_item;
        logic epoch_max;
    } csc_stat_t;

endpackage

/* hw/rtl/csc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all modulo work.
// Depends on csc_pkg.
module csc_div import csc_pkg::*; #(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int unsigned CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    // operand load on start, otherwise one shift-subtract step while busy
    always_comb begin
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff      = trial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_BITS'(VALUE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[VALUE_BITS]) begin
                rem_next = diff[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/csc_dp.sv */
// Datapath: gcd and factoring registers, shared divider, tagged prime bitmap.
// Depends on csc_pkg and csc_div.
module csc_dp import csc_pkg::*; #(
    parameter int unsigned     VALUE_BITS = VALUE_BITS_DEF,
    parameter longint unsigned SEEN_DEPTH = SEEN_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  csc_cmd_t              cmd,
    output csc_stat_t             stat,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  in_last_item,
    output logic [1:0]            out_verdict
);

    localparam int unsigned IDX_BITS = $clog2(SEEN_DEPTH);
    localparam bit NEED_MOD = (SEEN_DEPTH < (64'd1 << VALUE_BITS));
    localparam int unsigned SQ_BITS = VALUE_BITS + 2;

    logic [VALUE_BITS-1:0] x_reg, y_reg, n_reg, d_reg, p_reg, gcd_reg;
    logic [SQ_BITS-1:0]    dsq_reg;
    logic [IDX_BITS-1:0]   idx_reg, clr_addr_reg;
    logic [EPOCH_BITS-1:0] epoch_reg, rdata_reg;
    logic                  shared_reg, last_reg;
    verdict_t              verdict_reg;

    logic [VALUE_BITS-1:0] div_a, div_b, div_q, div_r, idx_val;
    logic                  div_busy, div_done;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [EPOCH_BITS-1:0] mem_wdata;

    logic [EPOCH_BITS-1:0] seen_mem [0:SEEN_DEPTH-1];

    // divider operand select
    always_comb begin
        case (cmd.div_sel)
            DIV_SEL_GCD: begin
                div_a = x_reg;
                div_b = y_reg;
            end
            DIV_SEL_FAC: begin
                div_a = n_reg;
                div_b = d_reg;
            end
            DIV_SEL_IDX: begin
                div_a = p_reg;
                div_b = VALUE_BITS'(SEEN_DEPTH);
            end
            default: begin
                div_a = x_reg;
                div_b = y_reg;
            end
        endcase
    end

    csc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign idx_val = NEED_MOD ? div_r : p_reg;

    // arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= gcd_reg;
            y_reg    <= in_value;
            n_reg    <= in_value;
            d_reg    <= VALUE_BITS'(2);
            dsq_reg  <= SQ_BITS'(4);
            last_reg <= in_last_item;
        end
        if (cmd.gcd_step) begin
            x_reg <= y_reg;
            y_reg <= div_r;
        end
        if (cmd.d_next) begin
            d_reg   <= d_reg + 1'b1;
            dsq_reg <= dsq_reg + SQ_BITS'({d_reg, 1'b1});
        end
        if (cmd.n_from_q) n_reg <= div_q;
        if (cmd.p_from_d) p_reg <= d_reg;
        if (cmd.p_from_n) p_reg <= n_reg;
        if (cmd.idx_load) idx_reg <= IDX_BITS'(idx_val);
        if (cmd.out_load) begin
            if (gcd_reg != VALUE_BITS'(1)) verdict_reg <= VERDICT_NOT_COPRIME;
            else if (shared_reg)           verdict_reg <= VERDICT_SETWISE;
            else                           verdict_reg <= VERDICT_PAIRWISE;
        end
    end

    // per-set state and clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gcd_reg      <= '0;
            shared_reg   <= 1'b0;
            epoch_reg    <= EPOCH_BITS'(1);
            clr_addr_reg <= '0;
        end else begin
            if (cmd.gcd_store) gcd_reg <= x_reg;
            if (cmd.mem_wr && (rdata_reg == epoch_reg)) shared_reg <= 1'b1;
            if (cmd.set_clear) begin
                gcd_reg    <= '0;
                shared_reg <= 1'b0;
                if (&epoch_reg) epoch_reg <= EPOCH_BITS'(1);
                else            epoch_reg <= epoch_reg + 1'b1;
            end
            if (cmd.clr_step) begin
                if (stat.clr_last) clr_addr_reg <= '0;
                else               clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // bitmap memory: entry is seen when its tag equals the current set tag
    assign mem_we    = cmd.clr_step | cmd.mem_wr;
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : idx_reg;
    assign mem_wdata = cmd.clr_step ? '0 : epoch_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) seen_mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd) rdata_reg <= seen_mem[idx_reg];
    end

    // status back to the controller
    always_comb begin
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.y_zero    = (y_reg == '0);
        stat.n_zero    = (n_reg == '0);
        stat.n_one     = (n_reg == VALUE_BITS'(1));
        stat.dsq_gt_n  = (dsq_reg > {2'b00, n_reg});
        stat.rem_zero  = (div_r == '0);
        stat.need_mod  = NEED_MOD;
        stat.clr_last  = (clr_addr_reg == IDX_BITS'(SEEN_DEPTH - 64'd1));
        stat.last_item = last_reg;
        stat.epoch_max = &epoch_reg;
    end

    assign out_verdict = verdict_reg;

endmodule

/* hw/rtl/csc_ctrl.sv */
// Controller state machine sequencing gcd, trial division and bitmap marking.
// Depends on csc_pkg and the assertion macro header.
`include "coprime_set_classifier_unit_macros.svh"

module csc_ctrl import csc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  csc_stat_t stat,
    output csc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GCD_TEST,
        S_GCD_DIV,
        S_FAC_TEST,
        S_FAC_DIV,
        S_MARK_IDX,
        S_MARK_MOD,
        S_MARK_RD,
        S_MARK_WR,
        S_STRIP_START,
        S_STRIP_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ret_fin_reg, ret_fin_next;
    logic   m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        ret_fin_next = ret_fin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_GCD_TEST;
                end
            end
            S_GCD_TEST: begin
                if (stat.y_zero) begin
                    cmd.gcd_store = 1'b1;
                    state_next    = S_FAC_TEST;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_GCD;
                    state_next    = S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                if (stat.div_done) begin
                    cmd.gcd_step = 1'b1;
                    state_next   = S_GCD_TEST;
                end
            end
            S_FAC_TEST: begin
                if (stat.n_zero) begin
                    state_next = S_FIN;
                end else if (stat.dsq_gt_n) begin
                    if (stat.n_one) begin
                        state_next = S_FIN;
                    end else begin
                        cmd.p_from_n = 1'b1;
                        ret_fin_next = 1'b1;
                        state_next   = S_MARK_IDX;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_FAC;
                    state_next    = S_FAC_DIV;
                end
            end
            S_FAC_DIV: begin
                if (stat.div_done) begin
                    if (stat.rem_zero) begin
                        cmd.n_from_q = 1'b1;
                        cmd.p_from_d = 1'b1;
                        ret_fin_next = 1'b0;
                        state_next   = S_MARK_IDX;
                    end else begin
                        cmd.d_next = 1'b1;
                        state_next = S_FAC_TEST;
                    end
                end
            end
            S_MARK_IDX: begin
                if (stat.need_mod) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_IDX;
                    state_next    = S_MARK_MOD;
                end else begin
                    cmd.idx_load = 1'b1;
                    state_next   = S_MARK_RD;
                end
            end
            S_MARK_MOD: begin
                if (stat.div_done) begin
                    cmd.idx_load = 1'b1;
                    state_next   = S_MARK_RD;
                end
            end
            S_MARK_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                cmd.mem_wr = 1'b1;
                state_next = ret_fin_reg ? S_FIN : S_STRIP_START;
            end
            S_STRIP_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_FAC;
                state_next    = S_STRIP_DIV;
            end
            S_STRIP_DIV: begin
                if (stat.div_done) begin
                    if (stat.rem_zero) begin
                        cmd.n_from_q = 1'b1;
                        state_next   = S_STRIP_START;
                    end else begin
                        cmd.d_next = 1'b1;
                        state_next = S_FAC_TEST;
                    end
                end
            end
            S_FIN: begin
                if (!stat.last_item) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    // hand over the verdict and start a fresh set
                    cmd.out_load  = 1'b1;
                    cmd.set_clear = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = stat.epoch_max ? S_CLEAR : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ret_fin_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_fin_reg <= ret_fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `CSC_ASSERT_IMPL(a_div_idle_on_start, aclk, aresetn, cmd.div_start, !stat.div_busy)
    `CSC_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.out_load, !(m_valid_reg && !m_ready))
    `CSC_ASSERT_NEXT(a_verdict_shown, aclk, aresetn, cmd.out_load, m_valid)
    `CSC_ASSERT_IMPL(a_no_mark_in_clear, aclk, aresetn, cmd.clr_step, !cmd.mem_wr && !s_ready)

endmodule

/* hw/rtl/coprime_set_classifier_unit.sv */
// Cost: each modulo runs in the one shared divider, so the time for an item grows with
//   the Euclid steps, trial divisors up to sqrt(value), prime-power strips and, when
//   SEEN_DEPTH is below 2**VALUE_BITS, marked primes.
// Throughput: one item at a time; the verdict of a last item waits in an output register.
// Reset: synchronous, active low; afterwards, and after every 255th set, a clearing pass
//   over every bitmap entry runs before an item is taken.
module coprime_set_classifier_unit import csc_pkg::*; #(
    parameter int unsigned     VALUE_BITS = VALUE_BITS_DEF,
    parameter longint unsigned SEEN_DEPTH = SEEN_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    input  logic                  s_last_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_verdict
);

    csc_cmd_t  cmd;
    csc_stat_t stat;

    // sequencing
    csc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and bitmap
    csc_dp #(
        .VALUE_BITS (VALUE_BITS),
        .SEEN_DEPTH (SEEN_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_value     (s_value),
        .in_last_item (s_last_item),
        .out_verdict  (m_verdict)
    );

endmodule
